/* rtl/core/sgi_pkg.sv */
// Shared constants and types for the segment intersection pipeline.
package sgi_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Control that travels with each request down the pipeline and the divider chain.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } sgi_ctl_t;

endpackage

/* rtl/core/sgi_if.sv */
// Valid/ready channel interfaces for segment pair requests and crossing results.
interface sgi_in_if import sgi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_start_mac;
  logic signed [COORD_WIDTH-1:0] a_start_weight;
  logic signed [COORD_WIDTH-1:0] a_end_mac;
  logic signed [COORD_WIDTH-1:0] a_end_weight;
  logic signed [COORD_WIDTH-1:0] b_start_mac;
  logic signed [COORD_WIDTH-1:0] b_start_weight;
  logic signed [COORD_WIDTH-1:0] b_end_mac;
  logic signed [COORD_WIDTH-1:0] b_end_weight;

  modport source (
    output valid, a_start_mac, a_start_weight, a_end_mac, a_end_weight,
           b_start_mac, b_start_weight, b_end_mac, b_end_weight,
    input  ready
  );
  modport sink (
    input  valid, a_start_mac, a_start_weight, a_end_mac, a_end_weight,
           b_start_mac, b_start_weight, b_end_mac, b_end_weight,
    output ready
  );
endinterface

interface sgi_out_if import sgi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] cross_mac;
  logic signed [COORD_WIDTH-1:0] cross_weight;

  modport source (output valid, hit, cross_mac, cross_weight, input ready);
  modport sink (input valid, hit, cross_mac, cross_weight, output ready);
endinterface

/* rtl/core/segment_intersection_top.sv */
// Segment intersection: exact crossing test and crossing point of two 2-D segments.
// From request to result a pair passes seven front stages, one division cell per
// quotient bit, and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) empties every stage; no clearing pass is needed.
module segment_intersection_top import sgi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sgi_in_if.sink    in_if,
  sgi_out_if.source out_if
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned MW = 2 * W + 1;

  logic adv;

  sgi_ctl_t      ctl_c     [0:W];
  logic [MW-1:0] den_c     [0:W];
  logic [W-1:0]  start_x_c [0:W];
  logic [W-1:0]  start_y_c [0:W];
  logic [MW-1:0] rem_x_c   [0:W];
  logic [MW-1:0] rem_y_c   [0:W];
  logic [W-1:0]  num_x_c   [0:W];
  logic [W-1:0]  num_y_c   [0:W];
  logic [W-1:0]  quo_x_c   [0:W];
  logic [W-1:0]  quo_y_c   [0:W];

  logic          out_valid_r, hit_r;
  logic [W-1:0]  cross_x_r, cross_y_r;
  logic [W-1:0]  cross_x_nxt, cross_y_nxt;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  sgi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_if.valid),
    .x1        (in_if.a_start_mac),
    .y1        (in_if.a_start_weight),
    .x2        (in_if.a_end_mac),
    .y2        (in_if.a_end_weight),
    .x3        (in_if.b_start_mac),
    .y3        (in_if.b_start_weight),
    .x4        (in_if.b_end_mac),
    .y4        (in_if.b_end_weight),
    .ctl_o     (ctl_c[0]),
    .den_o     (den_c[0]),
    .start_x_o (start_x_c[0]),
    .start_y_o (start_y_c[0]),
    .rem_x_o   (rem_x_c[0]),
    .rem_y_o   (rem_y_c[0]),
    .num_x_o   (num_x_c[0]),
    .num_y_o   (num_y_c[0])
  );

  assign quo_x_c[0] = '0;
  assign quo_y_c[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sgi_div_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .ctl_i     (ctl_c[i]),
      .den_i     (den_c[i]),
      .start_x_i (start_x_c[i]),
      .start_y_i (start_y_c[i]),
      .rem_x_i   (rem_x_c[i]),
      .rem_y_i   (rem_y_c[i]),
      .num_x_i   (num_x_c[i]),
      .num_y_i   (num_y_c[i]),
      .quo_x_i   (quo_x_c[i]),
      .quo_y_i   (quo_y_c[i]),
      .ctl_o     (ctl_c[i+1]),
      .den_o     (den_c[i+1]),
      .start_x_o (start_x_c[i+1]),
      .start_y_o (start_y_c[i+1]),
      .rem_x_o   (rem_x_c[i+1]),
      .rem_y_o   (rem_y_c[i+1]),
      .num_x_o   (num_x_c[i+1]),
      .num_y_o   (num_y_c[i+1]),
      .quo_x_o   (quo_x_c[i+1]),
      .quo_y_o   (quo_y_c[i+1])
    );
  end

  // The offset takes the sign of the direction; a miss reports the origin.
  always_comb begin
    cross_x_nxt = start_x_c[W] + (ctl_c[W].neg_x ? -quo_x_c[W] : quo_x_c[W]);
    cross_y_nxt = start_y_c[W] + (ctl_c[W].neg_y ? -quo_y_c[W] : quo_y_c[W]);
    if (!ctl_c[W].hit) begin
      cross_x_nxt = '0;
      cross_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_c[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r     <= ctl_c[W].hit;
      cross_x_r <= cross_x_nxt;
      cross_y_r <= cross_y_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.hit          = hit_r;
  assign out_if.cross_mac    = cross_x_r;
  assign out_if.cross_weight = cross_y_r;

endmodule

/* rtl/core/sgi_front.sv */
// Front pipeline: differences, cross products, hit test and numerator forming.
module sgi_front import sgi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] x1,
  input  logic signed [COORD_WIDTH-1:0] y1,
  input  logic signed [COORD_WIDTH-1:0] x2,
  input  logic signed [COORD_WIDTH-1:0] y2,
  input  logic signed [COORD_WIDTH-1:0] x3,
  input  logic signed [COORD_WIDTH-1:0] y3,
  input  logic signed [COORD_WIDTH-1:0] x4,
  input  logic signed [COORD_WIDTH-1:0] y4,
  output sgi_ctl_t                      ctl_o,
  output logic [2*COORD_WIDTH:0]        den_o,
  output logic [COORD_WIDTH-1:0]        start_x_o,
  output logic [COORD_WIDTH-1:0]        start_y_o,
  output logic [2*COORD_WIDTH:0]        rem_x_o,
  output logic [2*COORD_WIDTH:0]        rem_y_o,
  output logic [COORD_WIDTH-1:0]        num_x_o,
  output logic [COORD_WIDTH-1:0]        num_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned LW = 2 * W + 1;
  localparam int unsigned HW = 2 * W;
  localparam int unsigned NW = 3 * W + 1;

  sgi_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  sgi_ctl_t ctl2_nxt, ctl5_nxt;

  // Stage 1: coordinate differences.
  logic signed [DW-1:0] dxa_r, dya_r, dxb_r, dyb_r, dx13_r, dy13_r;
  logic [W-1:0]         sx1_r, sy1_r;
  // Stage 2: products and direction magnitudes.
  logic signed [PW-1:0] pd0_r, pd1_r, pt0_r, pt1_r, pu0_r, pu1_r;
  logic signed [DW-1:0] abs_x_nxt, abs_y_nxt;
  logic [W-1:0]         mag_x2_r, mag_y2_r, sx2_r, sy2_r;
  // Stage 3: denominator and numerators.
  logic signed [PW-1:0] den3_r, tn3_r, un3_r;
  logic [W-1:0]         mag_x3_r, mag_y3_r, sx3_r, sy3_r;
  // Stage 4: sign normalised.
  logic signed [PW-1:0] den4_r, tn4_r, un4_r;
  logic [W-1:0]         mag_x4_r, mag_y4_r, sx4_r, sy4_r;
  // Stage 5: hit decision.
  logic [MW-1:0]        den5_r, tn5_r;
  logic [W-1:0]         mag_x5_r, mag_y5_r, sx5_r, sy5_r;
  // Stage 6: partial products of the offset numerator.
  logic [LW-1:0]        lo_x6_r, lo_y6_r;
  logic [HW-1:0]        hi_x6_r, hi_y6_r;
  logic [MW-1:0]        den6_r;
  logic [W-1:0]         sx6_r, sy6_r;
  // Stage 7: full offset numerator.
  logic [NW-1:0]        n_x7_r, n_y7_r;
  logic [MW-1:0]        den7_r;
  logic [W-1:0]         sx7_r, sy7_r;

  always_comb begin
    abs_x_nxt = dxa_r[DW-1] ? -dxa_r : dxa_r;
    abs_y_nxt = dya_r[DW-1] ? -dya_r : dya_r;
    ctl2_nxt = ctl1_r;
    // The direction end minus start is the negated difference held here.
    ctl2_nxt.neg_x = (dxa_r > 0);
    ctl2_nxt.neg_y = (dya_r > 0);
    ctl5_nxt = ctl4_r;
    ctl5_nxt.hit = (den4_r != '0) && !tn4_r[PW-1] && (tn4_r <= den4_r) &&
                   !un4_r[PW-1] && (un4_r <= den4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else if (adv) begin
      ctl1_r <= '{valid: in_valid, hit: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      ctl2_r <= ctl2_nxt;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl5_nxt;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxa_r  <= DW'(x1) - DW'(x2);
      dya_r  <= DW'(y1) - DW'(y2);
      dxb_r  <= DW'(x3) - DW'(x4);
      dyb_r  <= DW'(y3) - DW'(y4);
      dx13_r <= DW'(x1) - DW'(x3);
      dy13_r <= DW'(y1) - DW'(y3);
      sx1_r  <= x1;
      sy1_r  <= y1;

      pd0_r    <= PW'(dxa_r) * PW'(dyb_r);
      pd1_r    <= PW'(dya_r) * PW'(dxb_r);
      pt0_r    <= PW'(dx13_r) * PW'(dyb_r);
      pt1_r    <= PW'(dy13_r) * PW'(dxb_r);
      pu0_r    <= PW'(dya_r) * PW'(dx13_r);
      pu1_r    <= PW'(dxa_r) * PW'(dy13_r);
      mag_x2_r <= abs_x_nxt[W-1:0];
      mag_y2_r <= abs_y_nxt[W-1:0];
      sx2_r    <= sx1_r;
      sy2_r    <= sy1_r;

      den3_r   <= pd0_r - pd1_r;
      tn3_r    <= pt0_r - pt1_r;
      un3_r    <= pu0_r - pu1_r;
      mag_x3_r <= mag_x2_r;
      mag_y3_r <= mag_y2_r;
      sx3_r    <= sx2_r;
      sy3_r    <= sy2_r;

      den4_r   <= den3_r[PW-1] ? -den3_r : den3_r;
      tn4_r    <= den3_r[PW-1] ? -tn3_r : tn3_r;
      un4_r    <= den3_r[PW-1] ? -un3_r : un3_r;
      mag_x4_r <= mag_x3_r;
      mag_y4_r <= mag_y3_r;
      sx4_r    <= sx3_r;
      sy4_r    <= sy3_r;

      den5_r   <= den4_r[MW-1:0];
      tn5_r    <= tn4_r[MW-1:0];
      mag_x5_r <= mag_x4_r;
      mag_y5_r <= mag_y4_r;
      sx5_r    <= sx4_r;
      sy5_r    <= sy4_r;

      // The numerator is split into a low and a high part to keep each multiplier narrow.
      lo_x6_r <= LW'(mag_x5_r) * LW'(tn5_r[W:0]);
      lo_y6_r <= LW'(mag_y5_r) * LW'(tn5_r[W:0]);
      hi_x6_r <= HW'(mag_x5_r) * HW'(tn5_r[MW-1:W+1]);
      hi_y6_r <= HW'(mag_y5_r) * HW'(tn5_r[MW-1:W+1]);
      den6_r  <= den5_r;
      sx6_r   <= sx5_r;
      sy6_r   <= sy5_r;

      n_x7_r <= NW'(lo_x6_r) + (NW'(hi_x6_r) << (W + 1));
      n_y7_r <= NW'(lo_y6_r) + (NW'(hi_y6_r) << (W + 1));
      den7_r <= den6_r;
      sx7_r  <= sx6_r;
      sy7_r  <= sy6_r;
    end
  end

  // The quotient fits in W bits, so the top bits already lie below the divisor.
  assign ctl_o     = ctl7_r;
  assign den_o     = den7_r;
  assign start_x_o = sx7_r;
  assign start_y_o = sy7_r;
  assign rem_x_o   = n_x7_r[NW-1:W];
  assign rem_y_o   = n_y7_r[NW-1:W];
  assign num_x_o   = n_x7_r[W-1:0];
  assign num_y_o   = n_y7_r[W-1:0];

endmodule

/* rtl/core/sgi_div_cell.sv */
// One restoring division cell: settles one quotient bit for both axes.
module sgi_div_cell import sgi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  sgi_ctl_t               ctl_i,
  input  logic [2*COORD_WIDTH:0] den_i,
  input  logic [COORD_WIDTH-1:0] start_x_i,
  input  logic [COORD_WIDTH-1:0] start_y_i,
  input  logic [2*COORD_WIDTH:0] rem_x_i,
  input  logic [2*COORD_WIDTH:0] rem_y_i,
  input  logic [COORD_WIDTH-1:0] num_x_i,
  input  logic [COORD_WIDTH-1:0] num_y_i,
  input  logic [COORD_WIDTH-1:0] quo_x_i,
  input  logic [COORD_WIDTH-1:0] quo_y_i,
  output sgi_ctl_t               ctl_o,
  output logic [2*COORD_WIDTH:0] den_o,
  output logic [COORD_WIDTH-1:0] start_x_o,
  output logic [COORD_WIDTH-1:0] start_y_o,
  output logic [2*COORD_WIDTH:0] rem_x_o,
  output logic [2*COORD_WIDTH:0] rem_y_o,
  output logic [COORD_WIDTH-1:0] num_x_o,
  output logic [COORD_WIDTH-1:0] num_y_o,
  output logic [COORD_WIDTH-1:0] quo_x_o,
  output logic [COORD_WIDTH-1:0] quo_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned MW = 2 * W + 1;

  sgi_ctl_t      ctl_r;
  logic [MW-1:0] den_r, rem_x_r, rem_y_r;
  logic [W-1:0]  start_x_r, start_y_r, num_x_r, num_y_r, quo_x_r, quo_y_r;

  logic [MW:0]   trial_x, trial_y, dext;
  logic          qbit_x, qbit_y;
  logic [MW:0]   diff_x, diff_y;
  logic [MW-1:0] rem_x_nxt, rem_y_nxt;

  always_comb begin
    dext      = {1'b0, den_i};
    trial_x   = {rem_x_i, num_x_i[W-1]};
    trial_y   = {rem_y_i, num_y_i[W-1]};
    qbit_x    = (trial_x >= dext);
    qbit_y    = (trial_y >= dext);
    diff_x    = trial_x - dext;
    diff_y    = trial_y - dext;
    rem_x_nxt = qbit_x ? diff_x[MW-1:0] : trial_x[MW-1:0];
    rem_y_nxt = qbit_y ? diff_y[MW-1:0] : trial_y[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r     <= den_i;
      start_x_r <= start_x_i;
      start_y_r <= start_y_i;
      rem_x_r   <= rem_x_nxt;
      rem_y_r   <= rem_y_nxt;
      num_x_r   <= num_x_i << 1;
      num_y_r   <= num_y_i << 1;
      quo_x_r   <= {quo_x_i[W-2:0], qbit_x};
      quo_y_r   <= {quo_y_i[W-2:0], qbit_y};
    end
  end

  assign ctl_o     = ctl_r;
  assign den_o     = den_r;
  assign start_x_o = start_x_r;
  assign start_y_o = start_y_r;
  assign rem_x_o   = rem_x_r;
  assign rem_y_o   = rem_y_r;
  assign num_x_o   = num_x_r;
  assign num_y_o   = num_y_r;
  assign quo_x_o   = quo_x_r;
  assign quo_y_o   = quo_y_r;

endmodule

/* tb/segment_intersection_top_tb.sv */
// Self-checking testbench for the segment intersection block: directed table, random requests.
module segment_intersection_top_tb;
  import sgi_pkg::*;

  localparam int unsigned CW          = COORD_WIDTH_DEF;
  localparam int          PERIOD      = 10;
  localparam int          LATENCY     = CW + 8;
  localparam int          LONG_HOLD   = 400;
  localparam int          PHASE_ITEMS = 360;
  localparam int          CYCLE_LIMIT = 400000;

  localparam logic [CW-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] C_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CW-1:0] a_start_mac;
    logic [CW-1:0] a_start_weight;
    logic [CW-1:0] a_end_mac;
    logic [CW-1:0] a_end_weight;
    logic [CW-1:0] b_start_mac;
    logic [CW-1:0] b_start_weight;
    logic [CW-1:0] b_end_mac;
    logic [CW-1:0] b_end_weight;
  } segment_pair_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] cross_mac;
    logic [CW-1:0] cross_weight;
  } crossing_t;

  typedef struct {
    segment_pair_t pair;
    bit            typed;
    crossing_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sgi_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  sgi_out_if #(.COORD_WIDTH(CW)) out_ch ();

  segment_intersection_top #(.COORD_WIDTH(CW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  crossing_t pending_crossings[$];
  stim_row_t directed_rows[$];

  int error_count    = 0;
  int pairs_sent     = 0;
  int results_seen   = 0;
  int hits_seen      = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // Offset of origin along dir by num/den of its length, truncated toward zero.
  function automatic logic [CW-1:0] scale_along(logic signed [127:0] origin,
                                                logic signed [127:0] dir,
                                                logic signed [127:0] num,
                                                logic signed [127:0] den);
    logic [127:0] mag;
    logic [127:0] offset;
    logic [127:0] point;
    mag = (dir < 0) ? -dir : dir;
    offset = (mag * num) / den;
    if (dir < 0) offset = -offset;
    point = origin + offset;
    return point[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(segment_pair_t p);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] den, tn, un;
    crossing_t r;
    x1 = $signed(p.a_start_mac);
    y1 = $signed(p.a_start_weight);
    x2 = $signed(p.a_end_mac);
    y2 = $signed(p.a_end_weight);
    x3 = $signed(p.b_start_mac);
    y3 = $signed(p.b_start_weight);
    x4 = $signed(p.b_end_mac);
    y4 = $signed(p.b_end_weight);
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    tn  = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
    un  = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
    r = '0;
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        tn  = -tn;
        un  = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        r.hit          = 1'b1;
        r.cross_mac    = scale_along(x1, x2 - x1, tn, den);
        r.cross_weight = scale_along(y1, y2 - y1, tn, den);
      end
    end
    return r;
  endfunction

  function automatic void add_row(bit typed, int x1, int y1, int x2, int y2,
                                  int x3, int y3, int x4, int y4,
                                  bit h = 1'b0, int cx = 0, int cy = 0);
    stim_row_t row;
    row.pair  = '{x1, y1, x2, y2, x3, y3, x4, y4};
    row.typed = typed;
    row.want  = '{h, cx, cy};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic segment_pair_t random_pair();
    int unsigned   pick;
    int            px, py, vx, vy, wx, wy, k1, k2, k3, k4;
    segment_pair_t p;
    pick = $urandom_range(99);
    px = int'($urandom_range(2097151)) - 1048576;
    py = int'($urandom_range(2097151)) - 1048576;
    vx = int'($urandom_range(2047)) - 1024;
    vy = int'($urandom_range(2047)) - 1024;
    wx = int'($urandom_range(2047)) - 1024;
    wy = int'($urandom_range(2047)) - 1024;
    k1 = $urandom_range(6);
    k2 = $urandom_range(6);
    k3 = $urandom_range(6);
    k4 = $urandom_range(6);
    if (pick < 40) begin
      // Both segments pass through one point unless the end of B is nudged; a zero step puts it on an endpoint.
      p = '{px - vx * k1, py - vy * k1, px + vx * k2, py + vy * k2,
            px - wx * k3, py - wy * k3, px + wx * k4, py + wy * k4};
      if ($urandom_range(3) == 0) p.b_end_mac = p.b_end_mac + $urandom_range(2) - 1;
      if ($urandom_range(3) == 0) p.b_end_weight = p.b_end_weight + $urandom_range(2) - 1;
    end else if (pick < 65) begin
      p = '{small_coord(), small_coord(), small_coord(), small_coord(),
            small_coord(), small_coord(), small_coord(), small_coord()};
    end else if (pick < 85) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (pick < 93) begin
      // Parallel, or collinear when the offset is zero.
      k3 = ($urandom_range(1) == 0) ? 0 : small_coord();
      p = '{px, py, px + vx * k2, py + vy * k2,
            px + vx * k1 + k3, py + vy * k1, px + vx * (k1 + k4) + k3, py + vy * (k1 + k4)};
    end else begin
      // One segment of zero length.
      p = '{px, py, px + vx, py + vy, px + wx, py + wy, px + wx, py + wy};
      if ($urandom_range(1) == 0) begin
        p.a_end_mac    = p.a_start_mac;
        p.a_end_weight = p.a_start_weight;
        p.b_end_mac    = p.b_start_mac + vx;
      end
    end
    return p;
  endfunction

  // Entered and left at a falling edge; holds the request until it is taken.
  task automatic offer_pair(input segment_pair_t p, input crossing_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.a_start_mac    = p.a_start_mac;
    in_ch.a_start_weight = p.a_start_weight;
    in_ch.a_end_mac      = p.a_end_mac;
    in_ch.a_end_weight   = p.a_end_weight;
    in_ch.b_start_mac    = p.b_start_mac;
    in_ch.b_start_weight = p.b_start_weight;
    in_ch.b_end_mac      = p.b_end_mac;
    in_ch.b_end_weight   = p.b_end_weight;
    do @(posedge clk); while (!in_ch.ready);
    pending_crossings.insert(pending_crossings.size(), want);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_crossings.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_crossings.size());
      $display("segment_intersection_top_tb: errors");
      $finish;
    end
  end

  // A long hold-off is loaded whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_crossings.size() == 0) begin
        report_mismatch("unexpected result", out_ch.cross_mac, '0);
      end else begin
        want = pending_crossings.pop_front();
        if (out_ch.hit !== want.hit) report_mismatch("hit", CW'(out_ch.hit), CW'(want.hit));
        if (out_ch.cross_mac !== want.cross_mac)
          report_mismatch("cross_mac", out_ch.cross_mac, want.cross_mac);
        if (out_ch.cross_weight !== want.cross_weight)
          report_mismatch("cross_weight", out_ch.cross_weight, want.cross_weight);
        if (out_ch.hit === 1'b1) hits_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    segment_pair_t p;
    int            wait_cycles;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.a_start_mac    = '0;
    in_ch.a_start_weight = '0;
    in_ch.a_end_mac      = '0;
    in_ch.a_end_weight   = '0;
    in_ch.b_start_mac    = '0;
    in_ch.b_start_weight = '0;
    in_ch.b_end_mac      = '0;
    in_ch.b_end_weight   = '0;
    out_ch.ready = 1'b0;

    add_row(1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    add_row(1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    add_row(1, 0, 0, 512, 512, 0, 512, 512, 0, 1, 256, 256);
    // Touch at the far end of A, and at the start of A.
    add_row(1, 0, 0, 512, 0, 512, 0, 512, 512, 1, 512, 0);
    add_row(1, 0, 0, 512, 512, -256, 0, 256, 0, 1, 0, 0);
    add_row(1, 0, 0, 256, 0, 512, -256, 512, 256);
    // Parallel, collinear overlapping and zero-length segments give no hit.
    add_row(1, 0, 0, 512, 0, 0, 256, 512, 256);
    add_row(1, 0, 0, 512, 0, 256, 0, 768, 0);
    add_row(1, 100, 100, 100, 100, 0, 0, 512, 512);
    add_row(1, 0, 0, 512, 512, 100, 100, 100, 100);
    add_row(1, C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, C_MAX, C_MAX);
    add_row(0, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
    add_row(0, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    add_row(0, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX);
    add_row(0, C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX);
    add_row(0, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
    add_row(0, 0, 0, -7, -5, -7, 0, 0, -5);
    add_row(0, 5, 3, -9, 11, -3, -2, 4, 9);
    add_row(0, 0, 0, 1024, 0, 256, 512, 256, 0);
    add_row(0, 0, 0, 512, 0, 256, 1, 256, 512);
    add_row(0, -1, -1, 1, 1, -1, 1, 1, -1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_pair(directed_rows[i].pair,
                 directed_rows[i].typed ? directed_rows[i].want
                                        : predict_crossing(directed_rows[i].pair));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The receiver goes quiet while requests keep coming, so the pipeline backs up.
        if (phase == 0 && i == 100) hold_requests++;
        // The sender stops until every outstanding result is back.
        if (phase == 1 && i == 180) drain_results();
        p = random_pair();
        offer_pair(p, predict_crossing(p));
      end
      drain_results();
    end

    wait_cycles = 0;
    while (wait_cycles < 2 * LATENCY) begin
      @(negedge clk);
      wait_cycles++;
    end

    $display("%0d segment pairs sent, %0d results checked, %0d of them hits,",
             pairs_sent, results_seen, hits_seen);
    $display("over free-running, sparse-sender, stalling-receiver and light-idle phases.");
    if (error_count == 0 && pending_crossings.size() == 0) begin
      $display("segment_intersection_top_tb: clean");
    end else begin
      $display("segment_intersection_top_tb: errors");
    end
    $finish;
  end

endmodule
